@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock edge outside reset.
`define QL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check a property at every clock edge, also while reset is active.
`define QL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");

`endif

@@ rtl/core/ql_pkg.sv @@
// Types, constants and arithmetic helpers of the Q-learning table block.
`default_nettype none
package ql_pkg;

  localparam int unsigned ACTIONS  = 64;
  localparam int unsigned STATES   = 1024;
  localparam int unsigned ACT_W    = $clog2(ACTIONS);
  localparam int unsigned ST_W     = $clog2(STATES);
  localparam int unsigned QADDR_W  = ST_W + ACT_W;
  localparam int unsigned SCNT_W   = ACT_W + 1;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned DIFF_W   = VAL_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int unsigned SHR_W    = PROD_W - 16;

  localparam logic [FRAC_W-1:0] LR_RESET    = 17'd6554;
  localparam logic [FRAC_W-1:0] GAMMA_RESET = 17'd62259;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic CFG_IDX_LR    = 1'b0;
  localparam logic CFG_IDX_GAMMA = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_TARGET,
    ST_ALPHA,
    ST_NEWV,
    ST_SCAN
  } ql_state_e;

  // Product shifted right by 16, truncated toward zero.
  function automatic logic signed [SHR_W-1:0] frac_shr(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    return adj[PROD_W-1:16];
  endfunction

  // Saturate to signed 32 bits.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
    logic [SHR_W-VAL_W:0] top;
    top = v[SHR_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      return v[VAL_W-1:0];
    end
    return v[SHR_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ql_intf.sv @@
// Handshake channel interfaces for input and result items.
`default_nettype none
interface ql_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [ql_pkg::ST_W-1:0]         state_index;
  logic [ql_pkg::ACT_W-1:0]        action_index;
  logic signed [ql_pkg::VAL_W-1:0] reward;
  logic [ql_pkg::ST_W-1:0]         next_state_index;

  modport source (output valid, mode, state_index, action_index, reward, next_state_index,
                  input ready);
  modport sink (input valid, mode, state_index, action_index, reward, next_state_index,
                output ready);
endinterface

interface ql_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ql_pkg::VAL_W-1:0] q_value;
  logic [ql_pkg::ACT_W-1:0]        best_action;
  logic signed [ql_pkg::VAL_W-1:0] best_value;

  modport source (output valid, q_value, best_action, best_value, input ready);
  modport sink (input valid, q_value, best_action, best_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/q_learning_table_update.sv @@
// Top level of the tabular Q-learning update and read block.
`default_nettype none
`include "assert_macros.svh"
// Q-learning table of 1024 states by 64 actions in signed Q16.16, with a cached best
// action and value per state row. After reset the block sweeps the table and the row
// caches to zero, one entry per cycle; input ready stays low during this sweep, while
// configuration writes are taken. A read item (mode 1) passes through the fetch and
// execute states to its result. In an update, one shared multiplier forms gamma*best and
// then alpha*(target - q). When the row's best action loses value, the row is rescanned
// through the single table read port, one entry per cycle. A new item is taken once the
// previous result has been delivered.
module q_learning_table_update (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ql_in_if.sink                      in_i,
  ql_out_if.source                   out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  // Configuration registers.
  logic [ql_pkg::FRAC_W-1:0] lr_q, gamma_q;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= ql_pkg::LR_RESET;
      gamma_q <= ql_pkg::GAMMA_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ql_pkg::CFG_IDX_LR) lr_q <= pwdata[ql_pkg::FRAC_W-1:0];
      else gamma_q <= pwdata[ql_pkg::FRAC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ql_pkg::CFG_IDX_GAMMA) prdata[ql_pkg::FRAC_W-1:0] = gamma_q;
    else prdata[ql_pkg::FRAC_W-1:0] = lr_q;
  end

  // Sequencer state and item registers.
  ql_pkg::ql_state_e state_q, state_d;
  logic [ql_pkg::QADDR_W-1:0]        clr_q, clr_d;
  logic [ql_pkg::SCNT_W-1:0]         scnt_q, scnt_d;
  logic signed [ql_pkg::VAL_W-1:0]   sbv_q, sbv_d;
  logic [ql_pkg::ACT_W-1:0]          sba_q, sba_d;
  logic signed [ql_pkg::VAL_W-1:0]   old_q, old_d;
  logic signed [ql_pkg::DIFF_W-1:0]  diff_q, diff_d;
  logic                              ovalid_q, ovalid_d;
  logic signed [ql_pkg::VAL_W-1:0]   oq_q, oq_d, obv_q, obv_d;
  logic [ql_pkg::ACT_W-1:0]          oba_q, oba_d;

  logic                              mode_q;
  logic [ql_pkg::ST_W-1:0]           s_q, ns_q;
  logic [ql_pkg::ACT_W-1:0]          a_q;
  logic signed [ql_pkg::VAL_W-1:0]   reward_q;

  // Memories and their registered read data.
  logic signed [ql_pkg::VAL_W-1:0] q_mem  [ql_pkg::STATES*ql_pkg::ACTIONS];
  logic signed [ql_pkg::VAL_W-1:0] bv_mem [ql_pkg::STATES];
  logic [ql_pkg::ACT_W-1:0]        ba_mem [ql_pkg::STATES];

  logic signed [ql_pkg::VAL_W-1:0] q_rd_q, bv_ns_q, bv_s_q;
  logic [ql_pkg::ACT_W-1:0]        ba_s_q;

  logic                            q_we;
  logic [ql_pkg::QADDR_W-1:0]      q_waddr, q_raddr;
  logic signed [ql_pkg::VAL_W-1:0] q_wdata;
  logic                            rb_we;
  logic [ql_pkg::ST_W-1:0]         rb_waddr;
  logic signed [ql_pkg::VAL_W-1:0] bv_wdata;
  logic [ql_pkg::ACT_W-1:0]        ba_wdata;

  // Shared multiplier.
  logic signed [ql_pkg::DIFF_W-1:0] mul_a;
  logic [ql_pkg::FRAC_W-1:0]        mul_b;
  logic signed [ql_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ql_pkg::PROD_W'(mul_a) * $signed({1'b0, mul_b});
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rd_q <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rb_we) begin
      bv_mem[rb_waddr] <= bv_wdata;
      ba_mem[rb_waddr] <= ba_wdata;
    end
    bv_ns_q <= bv_mem[ns_q];
    bv_s_q  <= bv_mem[s_q];
    ba_s_q  <= ba_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q   <= in_i.mode;
      s_q      <= in_i.state_index;
      a_q      <= in_i.action_index;
      reward_q <= in_i.reward;
      ns_q     <= in_i.next_state_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ql_pkg::ST_CLEAR;
      clr_q    <= '0;
      scnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      scnt_q   <= scnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sbv_q  <= sbv_d;
    sba_q  <= sba_d;
    old_q  <= old_d;
    diff_q <= diff_d;
    oq_q   <= oq_d;
    obv_q  <= obv_d;
    oba_q  <= oba_d;
  end

  assign in_i.ready        = (state_q == ql_pkg::ST_IDLE) && !ovalid_q;
  assign out_o.valid       = ovalid_q;
  assign out_o.q_value     = oq_q;
  assign out_o.best_action = oba_q;
  assign out_o.best_value  = obv_q;

  logic signed [ql_pkg::VAL_W-1:0] boot, target, delta, nv, sdata;
  logic [ql_pkg::ACT_W-1:0]        sidx;
  logic                            sbetter;

  always_comb begin
    boot   = ql_pkg::sat32(ql_pkg::frac_shr(prod_q));
    target = ql_pkg::sat32(ql_pkg::SHR_W'(reward_q) + ql_pkg::SHR_W'(boot));
    delta  = ql_pkg::sat32(ql_pkg::frac_shr(prod_q));
    nv     = ql_pkg::sat32(ql_pkg::SHR_W'(old_q) + ql_pkg::SHR_W'(delta));
    sdata  = q_rd_q;
    sidx   = ql_pkg::ACT_W'(scnt_q - ql_pkg::SCNT_W'(1));
    // First scanned entry always seeds; later ones replace only when strictly greater.
    sbetter = (scnt_q == ql_pkg::SCNT_W'(1)) || (sdata > sbv_q);
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    scnt_d   = scnt_q;
    sbv_d    = sbv_q;
    sba_d    = sba_q;
    old_d    = old_q;
    diff_d   = diff_q;
    ovalid_d = ovalid_q;
    oq_d     = oq_q;
    obv_d    = obv_q;
    oba_d    = oba_q;
    q_we     = 1'b0;
    q_waddr  = {s_q, a_q};
    q_wdata  = nv;
    q_raddr  = {s_q, a_q};
    rb_we    = 1'b0;
    rb_waddr = s_q;
    bv_wdata = nv;
    ba_wdata = a_q;
    mul_a    = ql_pkg::DIFF_W'(bv_ns_q);
    mul_b    = gamma_q;

    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;

    unique case (state_q)
      ql_pkg::ST_CLEAR: begin
        q_we     = 1'b1;
        q_waddr  = clr_q;
        q_wdata  = '0;
        rb_we    = 1'b1;
        rb_waddr = clr_q[ql_pkg::QADDR_W-1:ql_pkg::ACT_W];
        bv_wdata = '0;
        ba_wdata = '0;
        clr_d    = clr_q + ql_pkg::QADDR_W'(1);
        if (&clr_q) state_d = ql_pkg::ST_IDLE;
      end
      ql_pkg::ST_IDLE: begin
        if (in_i.valid && in_i.ready) state_d = ql_pkg::ST_FETCH;
      end
      ql_pkg::ST_FETCH: begin
        state_d = ql_pkg::ST_EXEC;
      end
      ql_pkg::ST_EXEC: begin
        old_d = q_rd_q;
        if (mode_q == ql_pkg::MODE_READ) begin
          oq_d     = q_rd_q;
          obv_d    = bv_s_q;
          oba_d    = ba_s_q;
          ovalid_d = 1'b1;
          state_d  = ql_pkg::ST_IDLE;
        end else begin
          state_d = ql_pkg::ST_TARGET;
        end
      end
      ql_pkg::ST_TARGET: begin
        diff_d  = ql_pkg::DIFF_W'(target) - ql_pkg::DIFF_W'(old_q);
        state_d = ql_pkg::ST_ALPHA;
      end
      ql_pkg::ST_ALPHA: begin
        mul_a   = diff_q;
        mul_b   = lr_q;
        state_d = ql_pkg::ST_NEWV;
      end
      ql_pkg::ST_NEWV: begin
        q_we = 1'b1;
        oq_d = nv;
        if (a_q == ba_s_q) begin
          if (nv >= bv_s_q) begin
            rb_we    = 1'b1;
            ba_wdata = ba_s_q;
            obv_d    = nv;
            oba_d    = ba_s_q;
            ovalid_d = 1'b1;
            state_d  = ql_pkg::ST_IDLE;
          end else begin
            scnt_d  = '0;
            state_d = ql_pkg::ST_SCAN;
          end
        end else begin
          rb_we    = nv > bv_s_q;
          obv_d    = (nv > bv_s_q) ? nv : bv_s_q;
          oba_d    = (nv > bv_s_q) ? a_q : ba_s_q;
          ovalid_d = 1'b1;
          state_d  = ql_pkg::ST_IDLE;
        end
      end
      ql_pkg::ST_SCAN: begin
        // Read data belongs to the address issued in the previous cycle.
        q_raddr = {s_q, scnt_q[ql_pkg::ACT_W-1:0]};
        scnt_d  = scnt_q + ql_pkg::SCNT_W'(1);
        if (scnt_q != '0 && sbetter) begin
          sbv_d = sdata;
          sba_d = sidx;
        end
        if (scnt_q == ql_pkg::SCNT_W'(ql_pkg::ACTIONS)) begin
          rb_we    = 1'b1;
          bv_wdata = sbetter ? sdata : sbv_q;
          ba_wdata = sbetter ? sidx : sba_q;
          obv_d    = bv_wdata;
          oba_d    = ba_wdata;
          ovalid_d = 1'b1;
          state_d  = ql_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ql_pkg::ST_IDLE;
      end
    endcase
  end

  `QL_ASSERT(a_accept_fetch, (in_i.valid && in_i.ready) |=> (state_q == ql_pkg::ST_FETCH))
  `QL_ASSERT(a_scan_bound, (state_q == ql_pkg::ST_SCAN) |-> (scnt_q <= ql_pkg::SCNT_W'(ql_pkg::ACTIONS)))
  `QL_ASSERT(a_no_result_busy, ovalid_q |-> (state_q == ql_pkg::ST_IDLE))
  `QL_ASSERT_ALWAYS(a_clear_not_ready, (state_q == ql_pkg::ST_CLEAR) |-> !in_i.ready)

endmodule
`default_nettype wire
